>>> rtl/core/ahfc_pkg.sv
package ahfc_pkg;

  // payload buffer sizing
  localparam int MAX_DATA_BYTES = 16;
  localparam int PCNT_W = $clog2(MAX_DATA_BYTES + 1);
  localparam int ADDR_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  // delay window holding CRC and trailer characters
  localparam int WINDOW_LEN = 4;
  localparam int WIN_IDX_W = $clog2(WINDOW_LEN);

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] START_CHAR = 8'h24;
  localparam logic [5:0] COUNT_MAX  = 6'd63;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CMD  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_CRC      = 3'd3,
    ST_HEX      = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_FINAL,
    S_READ,
    S_SEND
  } state_t;

  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_ctrl_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  // nibble to uppercase ASCII hex digit
  function automatic logic [7:0] upper_hex(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

  // {ok, value}; upper or lower case accepted
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h00;
    case (c) inside
      [8'h30:8'h39]: begin
        d = c - 8'h30;
        r = {1'b1, d[3:0]};
      end
      [8'h41:8'h46]: begin
        d = c - 8'h37;
        r = {1'b1, d[3:0]};
      end
      [8'h61:8'h66]: begin
        d = c - 8'h57;
        r = {1'b1, d[3:0]};
      end
      default: r = 5'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/ahfc_if.sv
interface ahfc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  logic       chunk_end;
  logic [7:0] expected_cmd;

  modport source (output valid, rx_char, chunk_end, expected_cmd, input ready);
  modport sink   (input valid, rx_char, chunk_end, expected_cmd, output ready);
endinterface

interface ahfc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       last_out;

  modport source (output valid, data_byte, byte_valid, status, last_out, input ready);
  modport sink   (input valid, data_byte, byte_valid, status, last_out, output ready);
endinterface

>>> rtl/core/ahfc_crc_unit.sv
// Bit-serial CRC-8, one polynomial step per cycle
module ahfc_crc_unit (
  input  logic              clk,
  input  logic              rst,
  input  ahfc_pkg::crc_ctrl_t ctrl,
  output logic              busy,
  output logic [7:0]        crc
);
  import ahfc_pkg::*;

  logic [2:0] step;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      crc  <= CRC_INIT;
      busy <= 1'b0;
      step <= 3'd0;
    end else if (ctrl.start) begin
      crc  <= crc ^ ctrl.data;
      busy <= 1'b1;
      step <= 3'd0;
    end else if (busy) begin
      crc  <= crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
      step <= step + 3'd1;
      if (step == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/ahfc_payload_buf.sv
// Payload byte store, one write and one registered read port
module ahfc_payload_buf (
  input  logic                        clk,
  input  ahfc_pkg::buf_wr_t           wr,
  input  logic [ahfc_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                  rd_data
);
  import ahfc_pkg::*;

  logic [7:0] mem [MAX_DATA_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/ascii_hex_frame_crc8_checker.sv
// Characters: a character that completes a body byte holds the input off
//   while the CRC unit runs.
// Frame end: end checks (S_FINAL), then a read and a send per data result
//   (S_READ, S_SEND) or a send alone for a status-only result; a send waits while the result side stalls.
// Reset (rst, synchronous): frame state cleared, CRC at 0xFF, window zeroed.
module ascii_hex_frame_crc8_checker (
  input logic          clk,
  input logic          rst,
  ahfc_char_if.sink    frame,
  ahfc_result_if.source result
);
  import ahfc_pkg::*;

  // ---------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------
  state_t state, state_next;

  logic [7:0]        win [WINDOW_LEN];     // last four characters
  logic [7:0]        win_next [WINDOW_LEN];
  logic [5:0]        char_count, char_count_next;
  logic [3:0]        nibble_hold, nibble_hold_next;
  logic              half_phase, half_phase_next;
  logic [1:0]        bytes_done, bytes_done_next; // saturates at 2
  logic [PCNT_W-1:0] payload_count, payload_count_next;
  status_t           error_code, error_code_next;
  logic              end_pend, end_pend_next;  // chunk_end seen, waiting on CRC
  status_t           status;                   // final frame status
  logic [ADDR_W-1:0] idx;                      // result being sent

  // shared units
  crc_ctrl_t  crc_ctrl;
  logic       crc_busy;
  logic [7:0] crc;
  buf_wr_t    buf_wr;
  logic [7:0] rd_data;

  logic       accept;
  logic       send_done;
  logic       last_item;
  logic       byte_done;   // accepted character completes a body byte
  logic [4:0] dec;
  logic [7:0] body_c;
  logic [7:0] pair;
  status_t    status_calc;

  ahfc_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .busy (crc_busy),
    .crc  (crc)
  );

  ahfc_payload_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign accept    = frame.valid && frame.ready;
  assign send_done = result.valid && result.ready;
  assign last_item = (payload_count == '0) ||
                     (PCNT_W'(idx) + PCNT_W'(1) == payload_count);

  // oldest window character becomes body once pushed out
  assign body_c = win[0];
  assign dec    = hex_decode(body_c);
  assign pair   = {nibble_hold, dec[3:0]};

  // ---------------------------------------------------------------
  // Per-character decode, window and flag update
  // ---------------------------------------------------------------
  always_comb begin
    win_next           = win;
    char_count_next    = char_count;
    nibble_hold_next   = nibble_hold;
    half_phase_next    = half_phase;
    bytes_done_next    = bytes_done;
    payload_count_next = payload_count;
    error_code_next    = error_code;
    end_pend_next      = end_pend;
    byte_done          = 1'b0;
    crc_ctrl           = '0;
    buf_wr             = '0;

    if (accept) begin
      end_pend_next = frame.chunk_end;
      if (char_count == '0) begin
        if (frame.rx_char != START_CHAR) begin
          error_code_next = ST_BAD_CMD;
        end
      end else begin
        if (char_count > 6'(WINDOW_LEN)) begin
          // body character; first error wins
          if (!dec[4] && error_code_next == ST_OK) begin
            error_code_next = ST_HEX;
          end
          if (!half_phase) begin
            if (bytes_done == 2'd0 &&
                body_c != upper_hex(frame.expected_cmd[7:4]) &&
                error_code_next == ST_OK) begin
              error_code_next = ST_BAD_CMD;
            end
            nibble_hold_next = dec[3:0];
            half_phase_next  = 1'b1;
          end else begin
            if (bytes_done == 2'd0 &&
                body_c != upper_hex(frame.expected_cmd[3:0]) &&
                error_code_next == ST_OK) begin
              error_code_next = ST_BAD_CMD;
            end
            byte_done     = 1'b1;
            crc_ctrl.start = 1'b1;
            crc_ctrl.data  = pair;
            if (bytes_done != 2'd0) begin
              if (payload_count < PCNT_W'(MAX_DATA_BYTES)) begin
                buf_wr.en          = 1'b1;
                buf_wr.addr        = payload_count[ADDR_W-1:0];
                buf_wr.data        = pair;
                payload_count_next = payload_count + PCNT_W'(1);
              end else if (error_code_next == ST_OK) begin
                error_code_next = ST_OVERFLOW;
              end
            end
            half_phase_next = 1'b0;
            if (bytes_done != 2'd2) begin
              bytes_done_next = bytes_done + 2'd1;
            end
          end
          // window full: shift
          for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_next[i] = win[i + 1];
          end
          win_next[WINDOW_LEN - 1] = frame.rx_char;
        end else begin
          // window filling
          win_next[WIN_IDX_W'(char_count - 6'd1)] = frame.rx_char;
        end
      end
      if (char_count != COUNT_MAX) begin
        char_count_next = char_count + 6'd1;
      end
    end

    // last result taken: clear for the next frame
    if (send_done && last_item) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_next[i] = 8'h00;
      end
      char_count_next    = '0;
      nibble_hold_next   = 4'h0;
      half_phase_next    = 1'b0;
      bytes_done_next    = 2'd0;
      payload_count_next = '0;
      error_code_next    = ST_OK;
      end_pend_next      = 1'b0;
      crc_ctrl.clear     = 1'b1;
    end
  end

  // end checks, only when streaming saw no error
  always_comb begin
    status_calc = error_code;
    if (error_code == ST_OK) begin
      if (bytes_done == 2'd0) begin
        status_calc = ST_SHORT;
      end else if (half_phase) begin
        status_calc = ST_HEX;
      end else if (win[0] != upper_hex(crc[7:4]) || win[1] != upper_hex(crc[3:0])) begin
        status_calc = ST_CRC;
      end
    end
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (byte_done) begin
            state_next = S_CRC;
          end else if (frame.chunk_end) begin
            state_next = S_FINAL;
          end
        end
      end
      S_CRC: begin
        if (!crc_busy) begin
          state_next = end_pend ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        state_next = (payload_count == '0) ? S_SEND : S_READ;
      end
      S_READ: state_next = S_SEND;
      S_SEND: begin
        if (send_done) begin
          state_next = last_item ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and result outputs
  always_comb begin
    frame.ready       = (state == S_IDLE);
    result.valid      = (state == S_SEND);
    result.byte_valid = (payload_count != '0);
    result.data_byte  = (payload_count != '0) ? rd_data : 8'h00;
    result.status     = status;
    result.last_out   = last_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      char_count    <= '0;
      nibble_hold   <= 4'h0;
      half_phase    <= 1'b0;
      bytes_done    <= 2'd0;
      payload_count <= '0;
      error_code    <= ST_OK;
      end_pend      <= 1'b0;
      status        <= ST_OK;
      idx           <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win[i] <= 8'h00;
      end
    end else begin
      state         <= state_next;
      char_count    <= char_count_next;
      nibble_hold   <= nibble_hold_next;
      half_phase    <= half_phase_next;
      bytes_done    <= bytes_done_next;
      payload_count <= payload_count_next;
      error_code    <= error_code_next;
      end_pend      <= end_pend_next;
      win           <= win_next;
      if (state == S_FINAL) begin
        status <= status_calc;
        idx    <= '0;
      end else if (send_done && !last_item) begin
        idx <= idx + ADDR_W'(1);
      end
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ahfc_pkg::*;

  // ---------------------------------------------------------------------------
  // Local types
  // ---------------------------------------------------------------------------

  // One character request as offered to the checker.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic [7:0] cmd;
  } char_req_t;

  // One result request as it should leave the checker.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    status_t    st;
    logic       last;
  } frame_res_t;

  // Ways of spoiling an otherwise well-formed frame.
  typedef enum int {
    FLAW_NONE,
    FLAW_CHAR,       // one character anywhere replaced by a random one
    FLAW_DROP,       // one body character dropped, so the body goes odd
    FLAW_BAD_HEX,    // a data character replaced by a non-hex neighbour
    FLAW_CRC,        // low CRC digit wrong
    FLAW_LOWER_CRC,  // CRC written in lowercase
    FLAW_TRAILER,    // trailer characters random (should not matter)
    FLAW_WRONG_CMD,  // expected_cmd differs from the echoed command
    FLAW_LOWER_CMD,  // command echoed in lowercase
    FLAW_BAD_START   // start character is not '$'
  } flaw_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int TOTAL_CHARS    = 250;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ahfc_char_if   char_bus ();
  ahfc_result_if result_bus ();

  ascii_hex_frame_crc8_checker dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (char_bus),
    .result (result_bus)
  );

  // ---------------------------------------------------------------------------
  // Stores shared between stimulus, prediction and checking
  // ---------------------------------------------------------------------------
  char_req_t  char_stream[$];        // characters still to be offered
  frame_res_t frame_results_due[$];  // predicted results, oldest first
  logic [7:0] frame_text[$];         // scratch text while a frame is built

  int errors        = 0;
  int chars_taken   = 0;
  int results_taken = 0;
  int quiet_cycles  = 0;

  // Predictor state: our own copy of the frame checker's state.
  logic [7:0] crc_acc;
  logic [7:0] win [WINDOW_LEN];
  logic [3:0] hi_nib;
  logic [5:0] n_chars;
  logic [7:0] payload [MAX_DATA_BYTES];
  int         n_payload;
  status_t    first_err;
  int         body_bytes;
  logic       odd_half;

  // ---------------------------------------------------------------------------
  // Helpers for the predictor and the frame builder
  // ---------------------------------------------------------------------------

  // Nibble to ASCII hex; letters in lowercase when asked.
  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) begin
      return 8'h30 + {4'h0, v};
    end
    return (lower ? 8'h57 : 8'h37) + {4'h0, v};
  endfunction

  // {ok, value}: digits keep their low nibble, letters of either case are low nibble + 9.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'h00;
  endfunction

  // CRC-8, poly 0x31, MSB first, one byte.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  task automatic clear_frame_state();
    crc_acc    = CRC_INIT;
    hi_nib     = 4'h0;
    n_chars    = 6'd0;
    n_payload  = 0;
    first_err  = ST_OK;
    body_bytes = 0;
    odd_half   = 1'b0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win[i] = 8'h00;
    end
  endtask

  // first error in a frame sticks
  task automatic note_err(input status_t s);
    if (first_err == ST_OK) begin
      first_err = s;
    end
  endtask

  // A character leaving the window becomes body: decode, check command, CRC, store.
  task automatic take_body(input logic [7:0] c, input logic [7:0] cmd);
    logic [4:0] dec;
    logic [7:0] b;
    dec = hex_val(c);
    if (!dec[4]) begin
      note_err(ST_HEX);
    end
    if (!odd_half) begin
      if (body_bytes == 0 && c != hex_char(cmd[7:4], 1'b0)) begin
        note_err(ST_BAD_CMD);
      end
      hi_nib   = dec[3:0];
      odd_half = 1'b1;
    end else begin
      if (body_bytes == 0 && c != hex_char(cmd[3:0], 1'b0)) begin
        note_err(ST_BAD_CMD);
      end
      b       = {hi_nib, dec[3:0]};
      crc_acc = crc8_next(crc_acc, b);
      // the first byte is the command; only later bytes are payload
      if (body_bytes != 0) begin
        if (n_payload < MAX_DATA_BYTES) begin
          payload[ADDR_W'(n_payload)] = b;
          n_payload++;
        end else begin
          note_err(ST_OVERFLOW);
        end
      end
      odd_half = 1'b0;
      if (body_bytes < 2) begin
        body_bytes++;
      end
    end
  endtask

  // Advance the predicted frame by one accepted character; at frame end queue the results.
  task automatic check_frame_char(input char_req_t r);
    status_t st;
    if (n_chars == 6'd0) begin
      if (r.ch != START_CHAR) begin
        note_err(ST_BAD_CMD);
      end
    end else begin
      if (n_chars > WINDOW_LEN) begin
        take_body(win[0], r.cmd);
      end
      if (int'(n_chars) - 1 >= WINDOW_LEN) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win[i] = win[i + 1];
        end
        win[WINDOW_LEN - 1] = r.ch;
      end else begin
        win[WIN_IDX_W'(n_chars - 6'd1)] = r.ch;
      end
    end
    if (n_chars < COUNT_MAX) begin
      n_chars++;
    end
    if (r.fin) begin
      // end checks only where nothing went wrong while streaming
      st = first_err;
      if (st == ST_OK) begin
        if (body_bytes == 0) begin
          st = ST_SHORT;
        end else if (odd_half) begin
          st = ST_HEX;
        end else if (win[0] != hex_char(crc_acc[7:4], 1'b0) ||
                     win[1] != hex_char(crc_acc[3:0], 1'b0)) begin
          st = ST_CRC;
        end
      end
      if (n_payload == 0) begin
        frame_results_due.push_back('{8'h00, 1'b0, st, 1'b1});
      end else begin
        for (int k = 0; k < n_payload; k++) begin
          frame_results_due.push_back('{payload[ADDR_W'(k)], 1'b1, st, k == n_payload - 1});
        end
      end
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_char(input logic [7:0] ch, input logic fin, input logic [7:0] cmd);
    char_stream.push_back('{ch, fin, cmd});
  endtask

  task automatic push_hex(input logic [7:0] b, input logic lower);
    frame_text.push_back(hex_char(b[7:4], lower));
    frame_text.push_back(hex_char(b[3:0], lower));
  endtask

  // Well-formed frame '$' cmd data* crc CR LF, then optionally one flaw.
  task automatic queue_frame(input logic [7:0] cmd, input int n_data, input flaw_t flaw);
    logic [7:0] crc;
    logic [7:0] b;
    logic [7:0] cmd_in;
    int         pos;
    frame_text.delete();
    frame_text.push_back(START_CHAR);
    push_hex(cmd, flaw == FLAW_LOWER_CMD);
    crc = crc8_next(CRC_INIT, cmd);
    for (int i = 0; i < n_data; i++) begin
      b   = 8'($urandom_range(255));
      crc = crc8_next(crc, b);
      frame_text.push_back(hex_char(b[7:4], 1'($urandom_range(1))));
      frame_text.push_back(hex_char(b[3:0], 1'($urandom_range(1))));
    end
    push_hex(crc, flaw == FLAW_LOWER_CRC);
    frame_text.push_back(8'h0D);
    frame_text.push_back(8'h0A);
    cmd_in = cmd;
    case (flaw)
      FLAW_CHAR: begin
        pos = $urandom_range(frame_text.size() - 1);
        frame_text[pos] = 8'($urandom_range(255));
      end
      FLAW_DROP: begin
        pos = $urandom_range(1, frame_text.size() - 5);
        frame_text.delete(pos);
      end
      FLAW_BAD_HEX: begin
        // boundary neighbours of the hex ranges
        if (n_data > 0) begin
          pos = $urandom_range(3, frame_text.size() - 5);
          case ($urandom_range(3))
            0: frame_text[pos] = 8'h2F;
            1: frame_text[pos] = 8'h3A;
            2: frame_text[pos] = 8'h40;
            default: frame_text[pos] = 8'h67;
          endcase
        end
      end
      FLAW_CRC: begin
        frame_text[frame_text.size() - 3] = hex_char(~crc[3:0], 1'b0);
      end
      FLAW_TRAILER: begin
        frame_text[frame_text.size() - 2] = 8'($urandom_range(255));
        frame_text[frame_text.size() - 1] = 8'($urandom_range(255));
      end
      FLAW_WRONG_CMD: begin
        cmd_in = cmd ^ (8'h01 << $urandom_range(7));
      end
      FLAW_BAD_START: begin
        frame_text[0] = START_CHAR ^ (8'h01 << $urandom_range(7));
      end
      default: begin
      end
    endcase
    foreach (frame_text[i]) begin
      add_char(frame_text[i], i == frame_text.size() - 1, cmd_in);
    end
  endtask

  // Random characters with a random command per character.
  task automatic queue_noise(input int len);
    for (int i = 0; i < len; i++) begin
      add_char((i == 0 && $urandom_range(1)) ? START_CHAR : 8'($urandom_range(255)),
               i == len - 1, 8'($urandom_range(255)));
    end
  endtask

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    if (errors < 100) begin
      $display("mismatch: %s got %0h want %0h (result %0d)", what, got, want,
               results_taken);
    end
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers character requests, predicts each one as it is taken.
  // A request held high is never dropped until it is taken.
  // ---------------------------------------------------------------------------
  char_req_t taken_char;
  logic      char_busy;
  logic      char_no_idle;

  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
    end else begin
      char_busy = char_bus.valid && !char_bus.ready;
      if (char_bus.valid && char_bus.ready) begin
        taken_char = char_stream.pop_front();
        check_frame_char(taken_char);
        chars_taken++;
      end
      // a solid run of back-to-back characters part way through
      char_no_idle = chars_taken >= 150 && chars_taken < 250;
      if (!char_busy) begin
        if (char_stream.size() != 0 && (char_no_idle || $urandom_range(99) >= 32)) begin
          char_bus.valid        <= 1'b1;
          char_bus.rx_char      <= char_stream[0].ch;
          char_bus.chunk_end    <= char_stream[0].fin;
          char_bus.expected_cmd <= char_stream[0].cmd;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result requests and checks each against the oldest one due.
  // Once, the result side holds off for a long stretch so that the checker
  // backs up and stalls its character input.
  // ---------------------------------------------------------------------------
  frame_res_t due;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (frame_results_due.size() == 0) begin
          report("result with nothing due, data", result_bus.data_byte, 8'h00);
        end else begin
          due = frame_results_due.pop_front();
          if (result_bus.data_byte !== due.data) begin
            report("data_byte", result_bus.data_byte, due.data);
          end
          if (result_bus.byte_valid !== due.has_byte) begin
            report("byte_valid", {7'h0, result_bus.byte_valid}, {7'h0, due.has_byte});
          end
          if (result_bus.status !== due.st) begin
            report("status", {5'h0, result_bus.status}, {5'h0, due.st});
          end
          if (result_bus.last_out !== due.last) begin
            report("last_out", {7'h0, result_bus.last_out}, {7'h0, due.last});
          end
        end
        results_taken++;
      end
      if (!hold_done && results_taken == 20) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (results_taken >= 40 && results_taken < 90) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any request moving on either side.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((char_bus.valid && char_bus.ready) ||
                 (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  int   n_frames;
  int   n_data;

  initial begin
    char_bus.valid        = 1'b0;
    char_bus.rx_char      = 8'h00;
    char_bus.chunk_end    = 1'b0;
    char_bus.expected_cmd = 8'h00;
    result_bus.ready      = 1'b0;
    clear_frame_state();

    // directed frames: extremes, every status, first error winning
    queue_frame(8'h00, 0, FLAW_NONE);           // command only, zero command
    queue_frame(8'hFF, 3, FLAW_NONE);           // all-ones command, mixed-case data
    queue_frame(8'hAB, MAX_DATA_BYTES, FLAW_NONE);      // buffer exactly full
    queue_frame(8'h5C, 30, FLAW_NONE);          // overflow; count saturates
    queue_frame(8'hAB, 17, FLAW_LOWER_CMD);     // bad command beats later overflow
    queue_frame(8'h3D, 1, FLAW_WRONG_CMD);
    queue_frame(8'h12, 1, FLAW_DROP);           // odd body
    queue_frame(8'h7E, 1, FLAW_BAD_HEX);
    queue_frame(8'h90, 1, FLAW_CRC);
    queue_frame(8'hCF, 1, FLAW_LOWER_CRC);
    queue_frame(8'h21, 0, FLAW_TRAILER);        // trailer is not checked
    queue_frame(8'h42, 0, FLAW_BAD_START);
    add_char(START_CHAR, 1'b1, 8'h00);          // lone start character
    add_char(START_CHAR, 1'b0, 8'h34);          // window never drains: too short
    add_char(8'h33, 1'b0, 8'h34);
    add_char(8'h34, 1'b0, 8'h34);
    add_char(8'h0D, 1'b0, 8'h34);
    add_char(8'h0A, 1'b1, 8'h34);
    add_char(8'h00, 1'b0, 8'hFF);               // extreme characters
    add_char(8'hFF, 1'b1, 8'h00);

    // random part: mostly well-formed frames with random content, up to the total
    n_frames = 0;
    while (char_stream.size() < TOTAL_CHARS || n_frames < 2) begin
      n_data = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
      case ($urandom_range(99)) inside
        [0:54]:  queue_frame(8'($urandom_range(255)), n_data, FLAW_NONE);
        [55:84]: queue_frame(8'($urandom_range(255)), n_data,
                             flaw_t'($urandom_range(int'(FLAW_BAD_START), 1)));
        default: queue_noise($urandom_range(1, 12));
      endcase
      n_frames++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sample on the falling edge, clear of the clocked processes
    while (char_stream.size() != 0 || char_bus.valid || frame_results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> ascii_hex_frame_crc8_checker.f
rtl/core/ahfc_pkg.sv
rtl/core/ahfc_if.sv
rtl/core/ahfc_crc_unit.sv
rtl/core/ahfc_payload_buf.sv
rtl/core/ascii_hex_frame_crc8_checker.sv
sim/testbench.sv
